>>> rtl/mswp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswp_pkg
// Shared types and constants for the multi-slot watchdog pool.
// ----------------------------------------------------------------------------
package mswp_pkg;

   localparam int SLOT_COUNT_DEF = 8;
   localparam int MAX_REPORTS    = 8;
   localparam int REP_W          = $clog2(MAX_REPORTS + 1);

   localparam logic [2:0] ACT_LOG      = 3'd0;
   localparam logic [2:0] ACT_FAILOVER = 3'd3;
   localparam logic [2:0] ACT_CUSTOM   = 3'd4;
   localparam logic [2:0] ACT_MAX      = 3'd4;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_INVALID      = 3'd1,
      ST_NOT_INIT     = 3'd2,
      ST_EXHAUSTED    = 3'd3,
      ST_NOT_KICKABLE = 3'd4,
      ST_LOCKED       = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      OP_INIT     = 4'd0,
      OP_SHUTDOWN = 4'd1,
      OP_CREATE   = 4'd2,
      OP_DESTROY  = 4'd3,
      OP_START    = 4'd4,
      OP_STOP     = 4'd5,
      OP_KICK     = 4'd6,
      OP_STATUS   = 4'd7,
      OP_TICK     = 4'd8,
      OP_FORCE    = 4'd9,
      OP_BAD      = 4'd10
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_ALLOC,
      BK_SCAN,
      BK_FLUSH
   } bk_state_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  idx;
      logic [31:0] now;
      logic [31:0] tmo;
      logic [2:0]  act;
      logic        bad_param;
   } cmd_type;

   typedef struct packed {
      logic [31:0] timeout;
      logic [2:0]  action;
      logic [31:0] deadline;
      logic [31:0] last_kick;
      logic [31:0] kicks;
      logic [31:0] fires;
      logic [31:0] recoveries;
   } slot_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  slot;
      logic        is_fire;
      logic [2:0]  action;
      logic        active;
      logic [31:0] kicks;
      logic [31:0] fires;
      logic [31:0] recoveries;
      logic [31:0] since_kick;
      logic [31:0] until_fire;
      logic        last;
   } result_type;

endpackage

>>> rtl/mswp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswp_front
// Request intake: decodes and checks each request, queues it for the engine.
// ----------------------------------------------------------------------------
module mswp_front
   import mswp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [3:0]  in_kind,
   input  logic [2:0]  in_idx,
   input  logic [31:0] in_now,
   input  logic [31:0] in_tmo,
   input  logic [2:0]  in_act,
   input  logic        in_hnd,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);

   cmd_type    q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    dec;
   logic       push, pop;

   always_comb begin
      dec.op  = (in_kind > 4'd9) ? OP_BAD : op_type'(in_kind);
      dec.idx = in_idx;
      dec.now = in_now;
      dec.tmo = in_tmo;
      dec.act = in_act;
      dec.bad_param = (in_tmo == 32'd0) || (in_act > ACT_MAX) ||
                      (((in_act == ACT_FAILOVER) || (in_act == ACT_CUSTOM)) && !in_hnd);
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= dec;
      end
   end

endmodule

>>> rtl/mswp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswp_engine
// Executes queued requests against the slot table and drives the result reg.
// ----------------------------------------------------------------------------
module mswp_engine
   import mswp_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       setup_locked,
   input  logic       cmd_valid,
   output logic       cmd_ready,
   input  cmd_type    cmd,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

   bk_state_type state_ff, state_in;
   cmd_type      cur_ff, cur_in;
   logic         ready_ff, ready_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in, run_ff, run_in, fired_ff, fired_in;
   slot_type     tab_ff [SLOT_COUNT];
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [REP_W-1:0] rep_ff, rep_in;
   logic         pend_ff, pend_in;
   logic [SLOT_W-1:0] pslot_ff, pslot_in;
   logic [2:0]   pact_ff, pact_in;
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_ff, rsp_in;

   logic [SLOT_W-1:0] sel;
   slot_type     ent, ent_in;
   logic         ent_wr;
   logic         out_free, in_range, hok, can_fire, due, scan_end;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign sel       = (state_ff == BK_EXEC) ? SLOT_W'(cur_ff.idx) : scan_ff[SLOT_W-1:0];
   assign ent       = tab_ff[sel];
   assign in_range  = (32'(cur_ff.idx) < SLOT_COUNT);
   assign hok       = in_range && used_ff[sel];
   assign can_fire  = used_ff[sel] && run_ff[sel] && !fired_ff[sel];
   assign due       = can_fire && (cur_ff.now >= ent.deadline);
   assign scan_end  = (scan_ff == CNT_W'(SLOT_COUNT - 1));

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      ready_in     = ready_ff;
      used_in      = used_ff;
      run_in       = run_ff;
      fired_in     = fired_ff;
      scan_in      = scan_ff;
      rep_in       = rep_ff;
      pend_in      = pend_ff;
      pslot_in     = pslot_ff;
      pact_in      = pact_ff;
      ent_in       = ent;
      ent_wr       = 1'b0;
      cmd_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         BK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cur_in  = cmd;
               scan_in = '0;
               rep_in  = '0;
               pend_in = 1'b0;
               if (cmd.op == OP_TICK) begin
                  state_in = ready_ff ? BK_SCAN : BK_IDLE;
               end else if (cmd.op == OP_CREATE && !cmd.bad_param && ready_ff &&
                            !setup_locked) begin
                  state_in = BK_ALLOC;
               end else begin
                  state_in = BK_EXEC;
               end
            end
         end

         BK_EXEC: begin
            if (out_free) begin
               state_in     = BK_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.last  = 1'b1;
               rsp_in.status = ST_OK;
               case (cur_ff.op)
                  OP_INIT: begin
                     if (!ready_ff) begin
                        used_in  = '0;
                        run_in   = '0;
                        fired_in = '0;
                        ready_in = 1'b1;
                     end
                  end
                  OP_SHUTDOWN: begin
                     run_in   = '0;
                     ready_in = 1'b0;
                  end
                  OP_CREATE: begin
                     if (cur_ff.bad_param)  rsp_in.status = ST_INVALID;
                     else if (!ready_ff)    rsp_in.status = ST_NOT_INIT;
                     else                   rsp_in.status = ST_LOCKED;
                  end
                  OP_DESTROY: begin
                     if (!hok) rsp_in.status = ST_INVALID;
                     else begin
                        run_in[sel]  = 1'b0;
                        used_in[sel] = 1'b0;
                     end
                  end
                  OP_START: begin
                     if (!hok) rsp_in.status = ST_INVALID;
                     else begin
                        run_in[sel]      = 1'b1;
                        fired_in[sel]    = 1'b0;
                        ent_in.deadline  = cur_ff.now + ent.timeout;
                        ent_in.last_kick = cur_ff.now;
                        ent_wr           = 1'b1;
                     end
                  end
                  OP_STOP: begin
                     if (!hok) rsp_in.status = ST_INVALID;
                     else run_in[sel] = 1'b0;
                  end
                  OP_KICK: begin
                     if (!hok) rsp_in.status = ST_INVALID;
                     else if (!run_ff[sel] || fired_ff[sel]) rsp_in.status = ST_NOT_KICKABLE;
                     else begin
                        ent_in.deadline  = cur_ff.now + ent.timeout;
                        ent_in.last_kick = cur_ff.now;
                        ent_in.kicks     = ent.kicks + 32'd1;
                        ent_wr           = 1'b1;
                     end
                  end
                  OP_STATUS: begin
                     if (!hok) rsp_in.status = ST_INVALID;
                     else begin
                        rsp_in.active     = run_ff[sel];
                        rsp_in.kicks      = ent.kicks;
                        rsp_in.fires      = ent.fires;
                        rsp_in.recoveries = ent.recoveries;
                        rsp_in.since_kick = (cur_ff.now >= ent.last_kick) ?
                                            cur_ff.now - ent.last_kick : 32'd0;
                        rsp_in.until_fire = (ent.deadline > cur_ff.now) ?
                                            ent.deadline - cur_ff.now : 32'd0;
                     end
                  end
                  OP_FORCE: begin
                     if (in_range && can_fire) begin
                        fired_in[sel]  = 1'b1;
                        ent_in.fires   = ent.fires + 32'd1;
                        if (ent.action != ACT_LOG) ent_in.recoveries = ent.recoveries + 32'd1;
                        ent_wr         = 1'b1;
                        rsp_in.slot    = 3'(sel);
                        rsp_in.is_fire = 1'b1;
                        rsp_in.action  = ent.action;
                     end
                  end
                  default: begin
                     rsp_in.status = ST_INVALID;
                  end
               endcase
            end
         end

         BK_ALLOC: begin
            if (out_free) begin
               if (!used_ff[sel] || scan_end) begin
                  state_in     = BK_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  rsp_in.last  = 1'b1;
                  rsp_in.status = ST_EXHAUSTED;
                  if (!used_ff[sel]) begin
                     used_in[sel]  = 1'b1;
                     run_in[sel]   = 1'b0;
                     fired_in[sel] = 1'b0;
                     ent_in        = '0;
                     ent_in.timeout = cur_ff.tmo;
                     ent_in.action  = cur_ff.act;
                     ent_wr        = 1'b1;
                     rsp_in.status = ST_OK;
                     rsp_in.slot   = 3'(sel);
                  end
               end else begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end
         end

         BK_SCAN: begin
            // a due slot with a report already held must wait for the output reg
            if (!(due && pend_ff && !out_free)) begin
               if (due) begin
                  fired_in[sel] = 1'b1;
                  ent_in.fires  = ent.fires + 32'd1;
                  if (ent.action != ACT_LOG) ent_in.recoveries = ent.recoveries + 32'd1;
                  ent_wr        = 1'b1;
                  if (pend_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_in         = '0;
                     rsp_in.slot    = 3'(pslot_ff);
                     rsp_in.is_fire = 1'b1;
                     rsp_in.action  = pact_ff;
                  end
                  pend_in  = 1'b1;
                  pslot_in = sel;
                  pact_in  = ent.action;
                  rep_in   = rep_ff + REP_W'(1);
               end
               scan_in = scan_ff + CNT_W'(1);
               if (scan_end || (due && rep_ff == REP_W'(MAX_REPORTS - 1))) begin
                  state_in = (pend_ff || due) ? BK_FLUSH : BK_IDLE;
               end
            end
         end

         BK_FLUSH: begin
            if (out_free) begin
               state_in       = BK_IDLE;
               pend_in        = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_in         = '0;
               rsp_in.slot    = 3'(pslot_ff);
               rsp_in.is_fire = 1'b1;
               rsp_in.action  = pact_ff;
               rsp_in.last    = 1'b1;
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ready_ff     <= 1'b0;
         used_ff      <= '0;
         run_ff       <= '0;
         fired_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         used_ff      <= used_in;
         run_ff       <= run_in;
         fired_ff     <= fired_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      scan_ff  <= scan_in;
      rep_ff   <= rep_in;
      pslot_ff <= pslot_in;
      pact_ff  <= pact_in;
      rsp_ff   <= rsp_in;
      if (ent_wr) begin
         tab_ff[sel] <= ent_in;
      end
   end

endmodule

>>> rtl/multi_slot_watchdog_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_watchdog_pool
// Pool of watchdog slots driven by timestamped requests over a stream port.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one transaction per request; the kind travels in req_tuser and
//    carries the caller's current millisecond time in req_tdata.
//  - rsp_*: every request except tick yields one transaction with tlast set.
//    A tick yields one fire report per due slot (at most 8, slot order),
//    tlast on the final one, or nothing when no slot is due.
//  - csr_*: writes the setup-lock bit; write only while the pool is idle.
//  - A two-entry request queue decouples intake from the engine, so up to
//    two requests are taken while the engine is busy or the output stalls.
//  - Each request passes the queue and the engine's command register. Create
//    walks the slots one per cycle while the result register is free, until
//    a free one; tick walks them one per cycle, a due slot waiting while a
//    report is held; the engine takes no new request until the walk ends.
//  - A stalled rsp_tready holds the result register; the engine waits.
//  - Reset (synchronous) empties the queue and leaves the pool uninitialized
//    with no slot in use and the lock bit clear.
// ----------------------------------------------------------------------------
module multi_slot_watchdog_pool
   import mswp_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // slot_index[2:0], now_ms[34:3], limit_ms[66:35], action_code[69:67],
   // handler_present[70], zero[71]
   input  logic [71:0]  req_tdata,
   // req_type[3:0]
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], result_slot[5:3], fire_action[8:6], slot_active[9],
   // kick_count[41:10], fire_count[73:42], recovery_count[105:74],
   // since_kick_ms[137:106], until_fire_ms[169:138], zero[175:170]
   output logic [175:0] rsp_tdata,
   // is_fire[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   logic       setup_locked_ff, setup_locked_in;
   logic       cmd_valid, cmd_ready;
   cmd_type    cmd;
   result_type res;

   // lock bit: always writable
   assign csr_ready       = 1'b1;
   assign setup_locked_in = (csr_valid && csr_ready) ? csr_data : setup_locked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_locked_ff <= 1'b0;
      end else begin
         setup_locked_ff <= setup_locked_in;
      end
   end

   mswp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (req_tuser),
      .in_idx    (req_tdata[2:0]),
      .in_now    (req_tdata[34:3]),
      .in_tmo    (req_tdata[66:35]),
      .in_act    (req_tdata[69:67]),
      .in_hnd    (req_tdata[70]),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   mswp_engine #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .setup_locked (setup_locked_ff),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp          (res)
   );

   // pack the result transaction
   assign rsp_tdata = {6'd0, res.until_fire, res.since_kick, res.recoveries, res.fires,
                       res.kicks, res.active, res.action, res.slot, res.status};
   assign rsp_tuser = res.is_fire;
   assign rsp_tlast = res.last;

endmodule
